@@ sv/rbca_pkg.sv @@
// rbca_pkg: shared types, widths and codes for the reorder buffer core
// used by reorder_buffer_cumulative_ack_core, rbca_alu and rbca_checker
// no dependencies
package rbca_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int SEQ_W     = 32;
    localparam int LEN_W     = 16;
    localparam int BYTES_W   = 20;
    localparam int SEGS_W    = 9;
    localparam int OUT_W     = 3;

    localparam logic [SEQ_W-1:0] INIT_BASE = 32'd1;

    typedef enum logic [OUT_W-1:0] {
        OUT_CORRUPT   = 3'd0,
        OUT_DUPLICATE = 3'd1,
        OUT_DELIVERED = 3'd2,
        OUT_BUFFERED  = 3'd3,
        OUT_FULL      = 3'd4
    } t_outcome;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT,
        ST_INSERT,
        ST_RUN,
        ST_ADVANCE,
        ST_COMPACT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
    } t_entry;

    typedef struct packed {
        logic               ack_valid;
        logic [SEQ_W-1:0]   ack_no;
        t_outcome           outcome;
        logic [BYTES_W-1:0] bytes;
        logic [SEGS_W-1:0]  segs;
    } t_result;

    // operands of the shared sequence unit: a + b, and c against d
    typedef struct packed {
        logic [SEQ_W-1:0] a;
        logic [SEQ_W-1:0] b;
        logic [SEQ_W-1:0] c;
        logic [SEQ_W-1:0] d;
    } t_alu_in;

    typedef struct packed {
        logic [SEQ_W-1:0] sum;
        logic             eq;
        logic             lt;
    } t_alu_out;

endpackage

@@ sv/rbca_alu.sv @@
// rbca_alu: shared 32-bit sequence unit, one wrapping add and one unsigned compare
// depends on rbca_pkg
module rbca_alu (
    input  rbca_pkg::t_alu_in  i_op,
    output rbca_pkg::t_alu_out o_res
);

    always_comb begin
        o_res.sum = i_op.a + i_op.b;
        o_res.eq  = (i_op.c == i_op.d);
        o_res.lt  = (i_op.c < i_op.d);
    end

endmodule

@@ sv/reorder_buffer_cumulative_ack_core.sv @@
// reorder_buffer_cumulative_ack_core: receive-side reorder buffer with cumulative ack
// depends on rbca_pkg and rbca_alu
//
//  channel   dir  handshake                       payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata seq,len; tuser checksum_ok; tlast fin
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata ack,bytes,segs; tuser ack_valid,outcome
//  cfg       in   i_cfg_valid/o_cfg_ready          i_cfg_data initial_base
//
// one segment word at a time; the shared sequence unit and the one-read one-write buffer
// memory set the time, which grows with the held entries scanned, the entries shifted,
// the run length and the entries moved
// corrupt and below-base words go from the check straight to the done state
// synchronous active-low reset: base = 1, buffer empty; no clearing pass
// a finished result waits in the output register while the next word is taken;
// a stalled output register holds the sequencer in its done state
// a config write reloads the base and empties the buffer
module reorder_buffer_cumulative_ack_core #(
    parameter int BUFFER_DEPTH = rbca_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input segment header
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // [31:0] seq_no, [47:32] data_length
    input  logic [0:0]  i_s_axis_tuser,   // [0] checksum_ok
    input  logic        i_s_axis_tlast,   // fin_flag
    // result
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [31:0] ack_no, [51:32] delivered_bytes,
                                          // [60:52] delivered_segments, [63:61] zero
    output logic [3:0]  o_m_axis_tuser,   // [0] ack_valid, [3:1] outcome
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data        // initial_base
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int SEQ_W   = rbca_pkg::SEQ_W;
    localparam int BYTES_W = rbca_pkg::BYTES_W;
    localparam int SEGS_W  = rbca_pkg::SEGS_W;

    // control state
    rbca_pkg::t_state   r_state, n_state;
    logic [SEQ_W-1:0]   r_base, n_base;
    logic [CW-1:0]      r_count, n_count;
    logic               r_out_valid, n_out_valid;
    logic               r_rv, n_rv;         // read data valid in r_rdata
    logic               r_brk, n_brk;       // read issue finished

    // working registers
    logic               r_ok, n_ok;
    logic [SEQ_W-1:0]   r_seq, n_seq;
    logic [15:0]        r_len, n_len;
    logic               r_fin, n_fin;
    logic [CW-1:0]      r_ra, n_ra;         // next read index
    logic [CW-1:0]      r_rtag, n_rtag;     // index of the data in r_rdata
    logic [CW-1:0]      r_pos, n_pos;       // held entries below the new seq
    logic               r_dup, n_dup;
    logic [CW-1:0]      r_run, n_run;
    logic [SEQ_W-1:0]   r_end, n_end;       // seq + len of last run entry
    logic [BYTES_W-1:0] r_bytes, n_bytes;
    rbca_pkg::t_result  r_pend, n_pend;
    rbca_pkg::t_result  r_res, n_res;

    // buffer memory, one read and one write port
    rbca_pkg::t_entry   r_mem [BUFFER_DEPTH];
    rbca_pkg::t_entry   r_rdata;
    logic               mem_re, mem_we;
    logic [CW-1:0]      rd_idx, wr_idx;
    logic [AW-1:0]      rd_addr, wr_addr;
    rbca_pkg::t_entry   wr_data;

    rbca_pkg::t_alu_in  alu_in;
    rbca_pkg::t_alu_out alu_out;

    logic [CW-1:0]      cnt_last;
    logic [BYTES_W:0]   bsum;
    logic [BYTES_W-1:0] bsat;
    logic               in_acc;

    rbca_alu u_alu (
        .i_op  (alu_in),
        .o_res (alu_out)
    );

    assign rd_addr  = rd_idx[AW-1:0];
    assign wr_addr  = wr_idx[AW-1:0];
    assign cnt_last = r_count - 1'b1;
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;

    // saturating byte total for the entry at the read port
    assign bsum = {1'b0, r_bytes} + (BYTES_W+1)'(r_rdata.len);
    assign bsat = bsum[BYTES_W] ? {BYTES_W{1'b1}} : bsum[BYTES_W-1:0];

    assign o_s_axis_tready = (r_state == rbca_pkg::ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_res.segs, r_res.bytes, r_res.ack_no};
    assign o_m_axis_tuser  = {r_res.outcome, r_res.ack_valid};

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_rv        = r_rv;
        n_brk       = r_brk;
        n_ok        = r_ok;
        n_seq       = r_seq;
        n_len       = r_len;
        n_fin       = r_fin;
        n_ra        = r_ra;
        n_rtag      = r_rtag;
        n_pos       = r_pos;
        n_dup       = r_dup;
        n_run       = r_run;
        n_end       = r_end;
        n_bytes     = r_bytes;
        n_pend      = r_pend;
        n_res       = r_res;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        rd_idx      = r_ra;
        wr_idx      = r_pos;
        wr_data     = r_rdata;
        alu_in      = '0;

        case (r_state)
            rbca_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_ok    = i_s_axis_tuser[0];
                    n_seq   = i_s_axis_tdata[31:0];
                    n_len   = i_s_axis_tdata[47:32];
                    n_fin   = i_s_axis_tlast;
                    n_state = rbca_pkg::ST_CHECK;
                end
            end

            rbca_pkg::ST_CHECK: begin
                alu_in.c            = r_seq;
                alu_in.d            = r_base;
                n_pend.ack_no       = r_base;
                n_pend.bytes        = '0;
                n_pend.segs         = '0;
                n_ra                = '0;
                n_pos               = '0;
                n_dup               = 1'b0;
                n_rv                = 1'b0;
                if (!r_ok) begin
                    n_pend.ack_valid = 1'b0;
                    n_pend.outcome   = rbca_pkg::OUT_CORRUPT;
                    n_state          = rbca_pkg::ST_DONE;
                end else if (alu_out.lt) begin
                    n_pend.ack_valid = 1'b1;
                    n_pend.outcome   = rbca_pkg::OUT_DUPLICATE;
                    n_state          = rbca_pkg::ST_DONE;
                end else if (r_count == '0) begin
                    n_state = rbca_pkg::ST_DECIDE;
                end else begin
                    n_state = rbca_pkg::ST_SCAN;
                end
            end

            // one held entry a cycle: equal seq is a duplicate, smaller ones set the slot
            rbca_pkg::ST_SCAN: begin
                n_rv = 1'b0;
                if (r_ra < r_count) begin
                    mem_re = 1'b1;
                    rd_idx = r_ra;
                    n_ra   = r_ra + 1'b1;
                    n_rtag = r_ra;
                    n_rv   = 1'b1;
                end
                if (r_rv) begin
                    alu_in.c = r_rdata.seq;
                    alu_in.d = r_seq;
                    if (alu_out.eq) begin
                        n_dup = 1'b1;
                    end
                    if (alu_out.lt) begin
                        n_pos = r_pos + 1'b1;
                    end
                    if (r_rtag == cnt_last) begin
                        n_state = rbca_pkg::ST_DECIDE;
                    end
                end
            end

            rbca_pkg::ST_DECIDE: begin
                n_brk = 1'b0;
                n_rv  = 1'b0;
                n_ra  = cnt_last;
                if (r_dup) begin
                    n_pend.ack_valid = 1'b1;
                    n_pend.outcome   = rbca_pkg::OUT_DUPLICATE;
                    n_state          = rbca_pkg::ST_DONE;
                end else if (r_count == CW'(BUFFER_DEPTH)) begin
                    n_pend.ack_valid = 1'b0;
                    n_pend.outcome   = rbca_pkg::OUT_FULL;
                    n_state          = rbca_pkg::ST_DONE;
                end else if (r_count == r_pos) begin
                    n_state = rbca_pkg::ST_INSERT;
                end else begin
                    n_state = rbca_pkg::ST_SHIFT;
                end
            end

            // move entries pos..count-1 up by one, from the top down
            rbca_pkg::ST_SHIFT: begin
                n_rv = 1'b0;
                if (!r_brk) begin
                    mem_re = 1'b1;
                    rd_idx = r_ra;
                    n_rtag = r_ra;
                    n_rv   = 1'b1;
                    if (r_ra == r_pos) begin
                        n_brk = 1'b1;
                    end else begin
                        n_ra = r_ra - 1'b1;
                    end
                end
                if (r_rv) begin
                    mem_we  = 1'b1;
                    wr_idx  = r_rtag + 1'b1;
                    wr_data = r_rdata;
                    if (r_rtag == r_pos) begin
                        n_state = rbca_pkg::ST_INSERT;
                    end
                end
            end

            rbca_pkg::ST_INSERT: begin
                mem_we      = 1'b1;
                wr_idx      = r_pos;
                wr_data.seq = r_seq;
                wr_data.len = r_len;
                n_count     = r_count + 1'b1;
                alu_in.c    = r_seq;
                alu_in.d    = r_base;
                n_ra        = '0;
                n_rv        = 1'b0;
                n_brk       = 1'b0;
                n_run       = '0;
                n_bytes     = '0;
                if (alu_out.eq) begin
                    n_state = rbca_pkg::ST_RUN;
                end else begin
                    n_pend.ack_valid = 1'b1;
                    n_pend.outcome   = rbca_pkg::OUT_BUFFERED;
                    n_state          = rbca_pkg::ST_DONE;
                end
            end

            // walk the contiguous run from entry 0
            rbca_pkg::ST_RUN: begin
                n_rv = 1'b0;
                if (!r_brk && (r_ra < r_count)) begin
                    mem_re = 1'b1;
                    rd_idx = r_ra;
                    n_ra   = r_ra + 1'b1;
                    n_rtag = r_ra;
                    n_rv   = 1'b1;
                end
                if (r_rv) begin
                    alu_in.a = r_rdata.seq;
                    alu_in.b = SEQ_W'(r_rdata.len);
                    alu_in.c = r_rdata.seq;
                    alu_in.d = r_end;
                    if ((r_rtag == '0) || alu_out.eq) begin
                        n_end   = alu_out.sum;
                        n_bytes = bsat;
                        n_run   = r_run + 1'b1;
                        if (r_rtag == cnt_last) begin
                            n_state = rbca_pkg::ST_ADVANCE;
                            n_rv    = 1'b0;
                            n_brk   = 1'b1;
                        end
                    end else begin
                        // gap found, drop the read already in flight
                        n_state = rbca_pkg::ST_ADVANCE;
                        n_rv    = 1'b0;
                        n_brk   = 1'b1;
                    end
                end
            end

            rbca_pkg::ST_ADVANCE: begin
                alu_in.a         = r_end;
                alu_in.b         = SEQ_W'(r_fin);
                n_base           = alu_out.sum;
                n_pend.ack_valid = 1'b1;
                n_pend.ack_no    = alu_out.sum;
                n_pend.outcome   = rbca_pkg::OUT_DELIVERED;
                n_pend.bytes     = r_bytes;
                n_pend.segs      = SEGS_W'(r_run);
                n_ra             = r_run;
                n_brk            = 1'b0;
                n_rv             = 1'b0;
                if (r_run == r_count) begin
                    n_count = '0;
                    n_state = rbca_pkg::ST_DONE;
                end else begin
                    n_state = rbca_pkg::ST_COMPACT;
                end
            end

            // move the entries after the run down to the head
            rbca_pkg::ST_COMPACT: begin
                n_rv = 1'b0;
                if (!r_brk) begin
                    mem_re = 1'b1;
                    rd_idx = r_ra;
                    n_rtag = r_ra;
                    n_rv   = 1'b1;
                    if (r_ra == cnt_last) begin
                        n_brk = 1'b1;
                    end else begin
                        n_ra = r_ra + 1'b1;
                    end
                end
                if (r_rv) begin
                    mem_we  = 1'b1;
                    wr_idx  = r_rtag - r_run;
                    wr_data = r_rdata;
                    if (r_rtag == cnt_last) begin
                        n_count = r_count - r_run;
                        n_rv    = 1'b0;
                        n_state = rbca_pkg::ST_DONE;
                    end
                end
            end

            rbca_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_res       = r_pend;
                    n_state     = rbca_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = rbca_pkg::ST_IDLE;
            end
        endcase

        // restart the stream on a config word
        if (i_cfg_valid && o_cfg_ready) begin
            n_base  = i_cfg_data;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rbca_pkg::ST_IDLE;
            r_base      <= rbca_pkg::INIT_BASE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rv        <= 1'b0;
            r_brk       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_rv        <= n_rv;
            r_brk       <= n_brk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok    <= n_ok;
        r_seq   <= n_seq;
        r_len   <= n_len;
        r_fin   <= n_fin;
        r_ra    <= n_ra;
        r_rtag  <= n_rtag;
        r_pos   <= n_pos;
        r_dup   <= n_dup;
        r_run   <= n_run;
        r_end   <= n_end;
        r_bytes <= n_bytes;
        r_pend  <= n_pend;
        r_res   <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

endmodule

@@ sv/rbca_checker.sv @@
// rbca_checker: port-level assertions for the reorder buffer core, bound to the top level
// depends on rbca_pkg and reorder_buffer_cumulative_ack_core
module rbca_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] i_m_tdata,
    input logic [3:0]  i_m_tuser
);

    logic [2:0]  outcome;
    logic        ack_valid;
    logic [19:0] bytes;
    logic [8:0]  segs;

    assign ack_valid = i_m_tuser[0];
    assign outcome   = i_m_tuser[3:1];
    assign bytes     = i_m_tdata[51:32];
    assign segs      = i_m_tdata[60:52];

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("result word changed while stalled");

    // sequencer is busy right after taking a segment
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("input ready right after accept");

    // only dropped segments go without ack
    a_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (ack_valid == !((outcome == rbca_pkg::OUT_CORRUPT) ||
                                      (outcome == rbca_pkg::OUT_FULL))))
        else $error("ack_valid does not match outcome");

    // counts only on delivery, and a delivery moves at least one segment
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> ((outcome == rbca_pkg::OUT_DELIVERED) ? (segs != 9'd0)
                                                             : ((bytes == 20'd0) && (segs == 9'd0))))
        else $error("delivery counts inconsistent with outcome");

endmodule

bind reorder_buffer_cumulative_ack_core rbca_checker u_rbca_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);
